// ----- hdl/pxw_pkg.sv -----
// shared types, constants and codes for the rotated packed pixel writer
// no dependencies
package pxw_pkg;

    localparam int COORD_BITS      = 12;
    localparam int SIZE_BITS       = COORD_BITS + 1;
    localparam int STRIDE_BITS     = 11;
    localparam int COLOUR_BITS     = 16;
    localparam int STORE_BYTES     = 65536;
    localparam int STORE_ADDR_BITS = $clog2(STORE_BYTES);
    localparam int ADDR_FULL_BITS  = COORD_BITS + STRIDE_BITS + 1;
    localparam int OUT_ADDR_BITS   = 16;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = SIZE_BITS;
    localparam int IN_DATA_BITS    = 40;
    localparam int OUT_DATA_BITS   = 32;

    localparam logic [31:0] STORE_LIMIT = 32'(STORE_BYTES);

    // pixel masks, msb first
    localparam logic [7:0] PIX1_MASK   = 8'h80;
    localparam logic [7:0] PIX2_MASK   = 8'hC0;
    localparam int         PIX2_SHIFT  = 6;

    typedef enum logic [1:0] {
        ST_WRITTEN = 2'd0,
        ST_LOGICAL = 2'd1,
        ST_MEMORY  = 2'd2,
        ST_BEYOND  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LOGICAL_WIDTH  = 3'd0,
        CFG_LOGICAL_HEIGHT = 3'd1,
        CFG_MEMORY_WIDTH   = 3'd2,
        CFG_MEMORY_HEIGHT  = 3'd3,
        CFG_ROW_BYTES      = 3'd4,
        CFG_ROTATION       = 3'd5,
        CFG_MIRROR_MODE    = 3'd6,
        CFG_TWO_BIT_MODE   = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP,
        S_ADDR,
        S_READ,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic [SIZE_BITS-1:0]   logical_width;
        logic [SIZE_BITS-1:0]   logical_height;
        logic [SIZE_BITS-1:0]   memory_width;
        logic [SIZE_BITS-1:0]   memory_height;
        logic [STRIDE_BITS-1:0] row_bytes;
        logic [1:0]             rotation;
        logic [1:0]             mirror_mode;
        logic                   two_bit_mode;
    } t_cfg;

    typedef struct packed {
        t_status                   status;
        logic [ADDR_FULL_BITS-1:0] addr;
        logic [2:0]                sub;
    } t_map_res;

    typedef struct packed {
        logic                       rd;
        logic                       wr;
        logic [STORE_ADDR_BITS-1:0] addr;
        logic [7:0]                 wdata;
    } t_mem_req;

endpackage

// ----- hdl/pxw_map.sv -----
// coordinate mapping and byte address unit, two register stages
// depends on pxw_pkg
module pxw_map
    import pxw_pkg::*;
(
    input  logic                   i_clk,
    input  t_cfg                   i_cfg,
    input  logic [COORD_BITS-1:0]  i_pos_x,
    input  logic [COORD_BITS-1:0]  i_pos_y,
    input  logic                   i_map_en,
    input  logic                   i_addr_en,
    output t_map_res               o_res
);

    logic [COORD_BITS-1:0] src_x, src_y;
    logic                  flip_x, flip_y;
    logic [SIZE_BITS-1:0]  inv_x, inv_y;
    t_status               st1;

    // a flipped coordinate can reach memory size minus one, past the logical range
    logic [SIZE_BITS-1:0]  r_mx, r_my;
    t_status               r_st1;

    logic [ADDR_FULL_BITS-1:0] addr;
    logic [SIZE_BITS-1:0]      col;
    logic [2:0]                sub;
    t_status                   st2;

    t_map_res r_res;

    // rotation then mirror collapses to an optional axis swap and an optional flip of each source axis
    always_comb begin
        src_x  = i_cfg.rotation[0] ? i_pos_y : i_pos_x;
        src_y  = i_cfg.rotation[0] ? i_pos_x : i_pos_y;
        flip_x = i_cfg.rotation[0] ^ i_cfg.rotation[1] ^ i_cfg.mirror_mode[0];
        flip_y = i_cfg.rotation[1] ^ i_cfg.mirror_mode[1];
        inv_x  = i_cfg.memory_width - SIZE_BITS'(1) - {1'b0, src_x};
        inv_y  = i_cfg.memory_height - SIZE_BITS'(1) - {1'b0, src_y};
        if ({1'b0, i_pos_x} >= i_cfg.logical_width ||
            {1'b0, i_pos_y} >= i_cfg.logical_height) begin
            st1 = ST_LOGICAL;
        end else if ({1'b0, src_x} >= i_cfg.memory_width ||
                     {1'b0, src_y} >= i_cfg.memory_height) begin
            st1 = ST_MEMORY;
        end else begin
            st1 = ST_WRITTEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_map_en) begin
            r_mx  <= flip_x ? inv_x : {1'b0, src_x};
            r_my  <= flip_y ? inv_y : {1'b0, src_y};
            r_st1 <= st1;
        end
    end

    always_comb begin
        if (i_cfg.two_bit_mode) begin
            col = r_mx >> 2;
            sub = {r_mx[1:0], 1'b0};
        end else begin
            col = r_mx >> 3;
            sub = r_mx[2:0];
        end
        addr = ADDR_FULL_BITS'(r_my) * ADDR_FULL_BITS'(i_cfg.row_bytes)
             + ADDR_FULL_BITS'(col);
        if (r_st1 == ST_WRITTEN && 32'(addr) >= STORE_LIMIT) begin
            st2 = ST_BEYOND;
        end else begin
            st2 = r_st1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_addr_en) begin
            r_res.status <= st2;
            r_res.addr   <= addr;
            r_res.sub    <= sub;
        end
    end

    assign o_res = r_res;

endmodule

// ----- hdl/pxw_store.sv -----
// byte frame store, one port, registered read, zero sweep after reset
// depends on pxw_pkg
module pxw_store
    import pxw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output logic     o_ready,
    output logic [7:0] o_rdata
);

    localparam logic [STORE_ADDR_BITS-1:0] LAST_ADDR = STORE_ADDR_BITS'(STORE_BYTES - 1);

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;
    logic [STORE_ADDR_BITS-1:0] r_clr_addr, n_clr_addr;
    logic r_clearing, n_clearing;

    logic                       we;
    logic [STORE_ADDR_BITS-1:0] waddr;
    logic [7:0]                 wdata;

    always_comb begin
        n_clr_addr = r_clr_addr;
        n_clearing = r_clearing;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + STORE_ADDR_BITS'(1);
            if (r_clr_addr == LAST_ADDR) begin
                n_clearing = 1'b0;
            end
        end
        we    = r_clearing | i_req.wr;
        waddr = r_clearing ? r_clr_addr : i_req.addr;
        wdata = r_clearing ? 8'd0 : i_req.wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_ready = ~r_clearing;
    assign o_rdata = r_rdata;

endmodule

// ----- hdl/rotated_packed_pixel_writer_top.sv -----
// top level of the rotated packed pixel writer: control, config, output slot
// depends on pxw_pkg, pxw_map and pxw_store
//
// usage
// - slave stream takes one pixel write request: x, y and colour
// - master stream returns one status request per pixel write, in order
// - config port writes one register per cycle with i_cfg_we; change it only
//   while no pixel write is in flight
// - each pixel is range checked against the logical area, mapped through
//   rotation and mirror, checked against the memory area, turned into a
//   byte address and then read-modify-written in the frame store
// - an accepted request passes S_MAP, S_ADDR, S_READ and S_WRITE; the result is then registered
// - the single store port serializes the read and the write of each pixel,
//   one pixel at a time; a new request waits until the last one is done
// - reset: config returns to its defaults and the store is swept to zero,
//   one byte per cycle, all STORE_BYTES (65536) bytes; s_axis_tready stays low
//   during the sweep, config writes are still taken
// - master stall: the finished result waits in the output register while
//   the next request is already accepted and processed; that one waits in
//   the last stage until the output register frees up
module rotated_packed_pixel_writer_top
    import pxw_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // config port
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // pixel write requests
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,  // pos_x[11:0], pos_y[23:12], colour[39:24]
    // results
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata   // status[1:0], byte_address[17:2],
                                                    // byte_value[25:18], zero[31:26]
);

    t_state r_state, n_state;
    t_cfg   r_cfg;

    // captured request
    logic [COORD_BITS-1:0]  r_pos_x, r_pos_y;
    logic [COLOUR_BITS-1:0] r_colour;

    // output slot
    logic                     r_out_valid;
    t_status                  r_out_status;
    logic [OUT_ADDR_BITS-1:0] r_out_addr;
    logic [7:0]               r_out_value;

    logic     in_accept;
    logic     map_en, addr_en, out_load;
    t_map_res map_res;
    t_mem_req mem_req;
    logic     store_ready;
    logic [7:0] rdata;
    logic [7:0] pix_mask, pix_bits, new_byte;
    logic       ok;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.logical_width  <= SIZE_BITS'(800);
            r_cfg.logical_height <= SIZE_BITS'(480);
            r_cfg.memory_width   <= SIZE_BITS'(800);
            r_cfg.memory_height  <= SIZE_BITS'(480);
            r_cfg.row_bytes      <= STRIDE_BITS'(100);
            r_cfg.rotation       <= 2'd0;
            r_cfg.mirror_mode    <= 2'd0;
            r_cfg.two_bit_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LOGICAL_WIDTH:  r_cfg.logical_width  <= i_cfg_data;
                CFG_LOGICAL_HEIGHT: r_cfg.logical_height <= i_cfg_data;
                CFG_MEMORY_WIDTH:   r_cfg.memory_width   <= i_cfg_data;
                CFG_MEMORY_HEIGHT:  r_cfg.memory_height  <= i_cfg_data;
                CFG_ROW_BYTES:      r_cfg.row_bytes      <= i_cfg_data[STRIDE_BITS-1:0];
                CFG_ROTATION:       r_cfg.rotation       <= i_cfg_data[1:0];
                CFG_MIRROR_MODE:    r_cfg.mirror_mode    <= i_cfg_data[1:0];
                CFG_TWO_BIT_MODE:   r_cfg.two_bit_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (store_ready) n_state = S_IDLE;
            S_IDLE:  if (s_axis_tvalid) n_state = S_MAP;
            S_MAP:   n_state = S_ADDR;
            S_ADDR:  n_state = S_READ;
            S_READ:  n_state = S_WRITE;
            S_WRITE: if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        map_en        = 1'b0;
        addr_en       = 1'b0;
        mem_req.rd    = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            S_IDLE:  s_axis_tready = 1'b1;
            S_MAP:   map_en        = 1'b1;
            S_ADDR:  addr_en       = 1'b1;
            S_READ:  mem_req.rd    = ok;
            S_WRITE: out_load      = ~r_out_valid | m_axis_tready;
            default: ;
        endcase
        mem_req.wr    = out_load & ok;
        mem_req.addr  = map_res.addr[STORE_ADDR_BITS-1:0];
        mem_req.wdata = new_byte;
    end

    assign in_accept = s_axis_tvalid & s_axis_tready;
    assign ok        = (map_res.status == ST_WRITTEN);

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pos_x  <= s_axis_tdata[11:0];
            r_pos_y  <= s_axis_tdata[23:12];
            r_colour <= s_axis_tdata[39:24];
        end
    end

    pxw_map u_map (
        .i_clk     (i_clk),
        .i_cfg     (r_cfg),
        .i_pos_x   (r_pos_x),
        .i_pos_y   (r_pos_y),
        .i_map_en  (map_en),
        .i_addr_en (addr_en),
        .o_res     (map_res)
    );

    // modify the fetched byte, msb-first pixel order
    always_comb begin
        if (r_cfg.two_bit_mode) begin
            pix_mask = PIX2_MASK >> map_res.sub;
            pix_bits = ({r_colour[1:0], 6'd0} >> map_res.sub);
        end else begin
            pix_mask = PIX1_MASK >> map_res.sub;
            pix_bits = (r_colour != '0) ? pix_mask : 8'd0;
        end
        new_byte = (rdata & ~pix_mask) | pix_bits;
    end

    pxw_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_ready (store_ready),
        .o_rdata (rdata)
    );

    // output slot, address and value read as zero unless written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= map_res.status;
            r_out_addr   <= ok ? map_res.addr[OUT_ADDR_BITS-1:0] : '0;
            r_out_value  <= ok ? new_byte : 8'd0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_value, r_out_addr, r_out_status};

endmodule
